@@ rtl/order_label_gap_split_core_macros.svh @@
// Assertion macros for the order label gap splitter.
// Included by the top level, which supplies clk and rst_n in scope.
`ifndef ORDER_LABEL_GAP_SPLIT_CORE_MACROS_SVH
`define ORDER_LABEL_GAP_SPLIT_CORE_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define OLGS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that an expression never holds outside reset.
`define OLGS_ASSERT_NEVER(name, expr, msg) \
    `OLGS_ASSERT(name, !(expr), msg)

`endif

@@ rtl/olgs_pkg.sv @@
// Shared types and constants for the order label gap splitter.
// Has no dependencies; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package olgs_pkg;

    localparam int LabelW  = 128;
    localparam int HalfW   = 64;
    localparam int CountW  = 7;
    localparam int StatusW = 2;
    localparam int InDataW = 264;
    localparam logic [CountW-1:0] MaxCount = 7'd64;
    localparam logic [CountW-1:0] DivLastBit = 7'd127;

    typedef enum logic [StatusW-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_ROOM   = 2'd1,
        STATUS_BAD_ORDER = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_MID,
        ST_DIV,
        ST_CHK,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/order_label_gap_split_core.sv @@
// Top level of the order label gap splitter: gap, midpoint and bit-serial division.
// Depends on olgs_pkg and order_label_gap_split_core_macros.svh.
// Bad bounds and a midpoint with no room give their result from the gap step, a midpoint
// label from the midpoint step after it. Distribute runs a bit-serial division of the gap,
// one quotient bit each division cycle, then a check: a no-room result comes from it, else
// each label from one shared 128-bit adder pass. One item is in work at a time and the next
// is taken the cycle after its last result is registered; output stalls hold each result.
// Reset (asynchronous, active low) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps
`include "order_label_gap_split_core_macros.svh"

module order_label_gap_split_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // left_high, left_low, right_high, right_low, count, zero pad
    input  logic [olgs_pkg::InDataW-1:0]  s_axis_tdata,
    // cmd
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // key_high, key_low
    output logic [olgs_pkg::LabelW-1:0]   m_axis_tdata,
    // status
    output logic [olgs_pkg::StatusW-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast
);

    olgs_pkg::state_t                   state_reg, state_next;
    logic [olgs_pkg::LabelW-1:0]        a_reg, a_next;
    logic [olgs_pkg::LabelW-1:0]        b_reg, b_next;
    logic                               cmd_reg, cmd_next;
    logic [olgs_pkg::CountW-1:0]        cnt_reg, cnt_next;
    logic [olgs_pkg::CountW-1:0]        den_reg, den_next;
    logic [olgs_pkg::CountW-1:0]        rem_reg, rem_next;
    logic [olgs_pkg::CountW-1:0]        bit_reg, bit_next;
    logic                               out_valid_reg, out_valid_next;
    logic [olgs_pkg::LabelW-1:0]        key_reg, key_next;
    olgs_pkg::status_t                  status_reg, status_next;
    logic                               last_reg, last_next;

    logic [olgs_pkg::LabelW-1:0]        op_a, op_b;
    logic                               op_sub;
    logic [olgs_pkg::LabelW:0]          sum;
    logic [olgs_pkg::CountW:0]          div_shift;
    logic [olgs_pkg::CountW:0]          div_diff;
    logic                               div_ge;
    logic                               out_free;
    logic [olgs_pkg::CountW-1:0]        in_count;
    logic [olgs_pkg::CountW-1:0]        clamped;
    logic [olgs_pkg::LabelW-1:0]        key_swapped;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == olgs_pkg::ST_IDLE);

    assign op_sub = (state_reg == olgs_pkg::ST_GAP);
    assign op_a   = op_sub ? b_reg : a_reg;
    assign op_b   = op_sub ? a_reg : b_reg;
    assign sum    = {1'b0, op_a} + {1'b0, op_b ^ {olgs_pkg::LabelW{op_sub}}}
                    + {{olgs_pkg::LabelW{1'b0}}, op_sub};

    assign div_shift = {rem_reg, b_reg[olgs_pkg::LabelW-1]};
    assign div_diff  = div_shift - {1'b0, den_reg};
    assign div_ge    = (div_shift >= {1'b0, den_reg});

    assign in_count = s_axis_tdata[4*olgs_pkg::HalfW +: olgs_pkg::CountW];
    always_comb
    begin
        if (in_count == '0)
        begin
            clamped = 7'd1;
        end
        else if (in_count > olgs_pkg::MaxCount)
        begin
            clamped = olgs_pkg::MaxCount;
        end
        else
        begin
            clamped = in_count;
        end
    end

    // The adder result is {high, low}; the output puts the high half in the lowest bits.
    assign key_swapped = {sum[olgs_pkg::HalfW-1:0], sum[olgs_pkg::LabelW-1:olgs_pkg::HalfW]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olgs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        cmd_reg    <= cmd_next;
        cnt_reg    <= cnt_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        bit_reg    <= bit_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            olgs_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    a_next     = {s_axis_tdata[0 +: olgs_pkg::HalfW],
                                  s_axis_tdata[olgs_pkg::HalfW +: olgs_pkg::HalfW]};
                    b_next     = {s_axis_tdata[2*olgs_pkg::HalfW +: olgs_pkg::HalfW],
                                  s_axis_tdata[3*olgs_pkg::HalfW +: olgs_pkg::HalfW]};
                    cmd_next   = s_axis_tuser;
                    cnt_next   = clamped;
                    den_next   = clamped + 7'd1;
                    state_next = olgs_pkg::ST_GAP;
                end
            end

            olgs_pkg::ST_GAP:
            begin
                // A carry out means right is not below left; a zero difference means equal.
                if (!sum[olgs_pkg::LabelW] || sum[olgs_pkg::LabelW-1:0] == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        key_next       = '0;
                        status_next    = olgs_pkg::STATUS_BAD_ORDER;
                        last_next      = 1'b1;
                        state_next     = olgs_pkg::ST_IDLE;
                    end
                end
                else if (cmd_reg)
                begin
                    if (sum[olgs_pkg::LabelW-1:1] == '0)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            key_next       = '0;
                            status_next    = olgs_pkg::STATUS_NO_ROOM;
                            last_next      = 1'b1;
                            state_next     = olgs_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        b_next     = {1'b0, sum[olgs_pkg::LabelW-1:1]};
                        state_next = olgs_pkg::ST_MID;
                    end
                end
                else
                begin
                    b_next     = sum[olgs_pkg::LabelW-1:0];
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = olgs_pkg::ST_DIV;
                end
            end

            olgs_pkg::ST_MID:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    key_next       = key_swapped;
                    status_next    = olgs_pkg::STATUS_OK;
                    last_next      = 1'b1;
                    state_next     = olgs_pkg::ST_IDLE;
                end
            end

            olgs_pkg::ST_DIV:
            begin
                rem_next = div_ge ? div_diff[olgs_pkg::CountW-1:0]
                                  : div_shift[olgs_pkg::CountW-1:0];
                b_next   = {b_reg[olgs_pkg::LabelW-2:0], div_ge};
                bit_next = bit_reg + 7'd1;
                if (bit_reg == olgs_pkg::DivLastBit)
                begin
                    state_next = olgs_pkg::ST_CHK;
                end
            end

            olgs_pkg::ST_CHK:
            begin
                if (b_reg[olgs_pkg::LabelW-1:1] == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        key_next       = '0;
                        status_next    = olgs_pkg::STATUS_NO_ROOM;
                        last_next      = 1'b1;
                        state_next     = olgs_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = olgs_pkg::ST_EMIT;
                end
            end

            olgs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    a_next         = sum[olgs_pkg::LabelW-1:0];
                    out_valid_next = 1'b1;
                    key_next       = key_swapped;
                    status_next    = olgs_pkg::STATUS_OK;
                    last_next      = (cnt_reg == 7'd1);
                    cnt_next       = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        state_next = olgs_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = olgs_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = key_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

    `OLGS_ASSERT(a_rem_below_den, (state_reg == olgs_pkg::ST_DIV) |-> (rem_reg < den_reg), "Division remainder reached the divisor.")
    `OLGS_ASSERT(a_fail_is_last, (out_valid_reg && status_reg != olgs_pkg::STATUS_OK) |-> (last_reg && key_reg == '0), "Failure result is not a single zero label.")
    `OLGS_ASSERT_NEVER(a_emit_count_zero, (state_reg == olgs_pkg::ST_EMIT) && (cnt_reg == '0), "Emitting with no labels left.")
    `OLGS_ASSERT(a_accept_starts_gap, (s_axis_tvalid && s_axis_tready) |=> (state_reg == olgs_pkg::ST_GAP), "Accepted transaction did not start the gap step.")

endmodule

@@ tb/tb_order_label_gap_split_core.sv @@
// Self-checking testbench for order_label_gap_split_core: midpoint and distribute splits.
// Directed table, then random gaps and counts, checked by a built-in label predictor or a known status.
// Depends on olgs_pkg and the order_label_gap_split_core RTL.
`timescale 1ns / 1ps

module tb_order_label_gap_split_core;

    localparam int LabelW  = olgs_pkg::LabelW;
    localparam int HalfW   = olgs_pkg::HalfW;
    localparam int CountW  = olgs_pkg::CountW;
    localparam int StatusW = olgs_pkg::StatusW;
    localparam int InDataW = olgs_pkg::InDataW;
    localparam logic [CountW-1:0] MaxCount = olgs_pkg::MaxCount;

    localparam logic CMD_DISTRIBUTE = 1'b0;
    localparam logic CMD_MIDPOINT   = 1'b1;
    localparam logic [LabelW-1:0] LABEL_MAX = '1;
    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_IDLE = 6;
    localparam int DRAIN_CYCLES = 250;

    typedef struct packed {
        logic [HalfW-1:0]  key_high;
        logic [HalfW-1:0]  key_low;
        olgs_pkg::status_t status;
        logic              last;
    } label_res_t;

    typedef struct {
        logic              cmd;
        logic [LabelW-1:0] left_label;
        logic [LabelW-1:0] right_label;
        logic [CountW-1:0] count;
        logic              known;
        olgs_pkg::status_t known_status;
    } split_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [InDataW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [LabelW-1:0] m_axis_tdata;
    logic [StatusW-1:0] m_axis_tuser;
    logic m_axis_tlast;

    label_res_t expected_labels[$];
    int errors = 0;
    int send_calm = 0;
    int recv_calm = 0;

    split_row_t directed_rows [0:19] = '{
        '{CMD_MIDPOINT,   128'd0, LABEL_MAX, 7'd1, 1'b0, olgs_pkg::STATUS_OK},
        '{CMD_MIDPOINT,   128'd5, 128'd6, 7'd1, 1'b1, olgs_pkg::STATUS_NO_ROOM},
        '{CMD_MIDPOINT,   128'd0, 128'd0, 7'd1, 1'b1, olgs_pkg::STATUS_BAD_ORDER},
        '{CMD_MIDPOINT,   LABEL_MAX, 128'd0, 7'd127, 1'b1, olgs_pkg::STATUS_BAD_ORDER},
        '{CMD_DISTRIBUTE, LABEL_MAX, LABEL_MAX, 7'd1, 1'b1, olgs_pkg::STATUS_BAD_ORDER},
        '{CMD_DISTRIBUTE, 128'd0, LABEL_MAX, 7'd64, 1'b0, olgs_pkg::STATUS_OK},
        '{CMD_DISTRIBUTE, 128'd0, 128'd1000, 7'd0, 1'b0, olgs_pkg::STATUS_OK},
        '{CMD_DISTRIBUTE, 128'd0, {1'b1, 127'd0}, 7'd127, 1'b0, olgs_pkg::STATUS_OK},
        '{CMD_DISTRIBUTE, 128'd100, 128'd103, 7'd1, 1'b1, olgs_pkg::STATUS_NO_ROOM},
        '{CMD_DISTRIBUTE, 128'd0, 128'd4, 7'd1, 1'b0, olgs_pkg::STATUS_OK},
        '{CMD_DISTRIBUTE, 128'd0, 128'd129, 7'd64, 1'b1, olgs_pkg::STATUS_NO_ROOM},
        '{CMD_DISTRIBUTE, 128'd0, 128'd130, 7'd64, 1'b0, olgs_pkg::STATUS_OK},
        '{CMD_DISTRIBUTE, {64'hFFFF_FFFF_FFFF_FFFE, 64'd0}, LABEL_MAX, 7'd3, 1'b0,
          olgs_pkg::STATUS_OK},
        '{CMD_MIDPOINT,   {64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, {64'd2, 64'd0}, 7'd0, 1'b0,
          olgs_pkg::STATUS_OK},
        '{CMD_DISTRIBUTE, 128'h1234, {64'd1, 64'd0}, 7'd65, 1'b0, olgs_pkg::STATUS_OK},
        '{CMD_MIDPOINT,   128'd0, 128'd3, 7'd0, 1'b0, olgs_pkg::STATUS_OK},
        '{CMD_DISTRIBUTE, 128'd0, 128'd3, 7'd0, 1'b1, olgs_pkg::STATUS_NO_ROOM},
        '{CMD_DISTRIBUTE, {64'd8, 64'd0}, {64'd8, 64'd1}, 7'd1, 1'b1,
          olgs_pkg::STATUS_NO_ROOM},
        '{CMD_DISTRIBUTE, {64'd1, 64'd0}, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 7'd7, 1'b1,
          olgs_pkg::STATUS_BAD_ORDER},
        '{CMD_MIDPOINT,   LABEL_MAX - 128'd1, LABEL_MAX, 7'd0, 1'b1, olgs_pkg::STATUS_NO_ROOM}
    };

    order_label_gap_split_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void push_label(input logic [LabelW-1:0] label,
                                       input olgs_pkg::status_t status, input logic last);
        label_res_t res;
        res.key_high = label[LabelW-1:HalfW];
        res.key_low  = label[HalfW-1:0];
        res.status   = status;
        res.last     = last;
        expected_labels.push_back(res);
    endfunction

    // Works out every label that one request yields, in emission order.
    function automatic void predict_labels(input logic cmd, input logic [LabelW-1:0] lower,
                                           input logic [LabelW-1:0] upper,
                                           input logic [CountW-1:0] count);
        logic [LabelW-1:0] gap;
        logic [LabelW-1:0] step;
        logic [LabelW-1:0] cur;
        int n;
        if (lower >= upper)
        begin
            push_label('0, olgs_pkg::STATUS_BAD_ORDER, 1'b1);
            return;
        end
        gap = upper - lower;
        if (cmd == CMD_MIDPOINT)
        begin
            step = gap >> 1;
            if (step == '0)
                push_label('0, olgs_pkg::STATUS_NO_ROOM, 1'b1);
            else
                push_label(lower + step, olgs_pkg::STATUS_OK, 1'b1);
            return;
        end
        n = (count == '0) ? 1 : ((count > MaxCount) ? int'(MaxCount) : int'(count));
        step = gap / LabelW'(n + 1);
        if (step < 2)
        begin
            push_label('0, olgs_pkg::STATUS_NO_ROOM, 1'b1);
            return;
        end
        cur = lower;
        for (int i = 0; i < n; i++)
        begin
            cur = cur + step;
            push_label(cur, olgs_pkg::STATUS_OK, i == n - 1);
        end
    endfunction

    function automatic logic [LabelW-1:0] random_label();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic int draw_idle(ref int calm);
        if (calm == 0 && $urandom_range(0, 9) == 0)
            calm = $urandom_range(10, 30);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Called at a rising edge; returns at the edge where the request transaction is taken.
    task automatic send_split(input logic cmd, input logic [LabelW-1:0] lower,
                              input logic [LabelW-1:0] upper, input logic [CountW-1:0] count,
                              input logic known, input olgs_pkg::status_t known_status);
        int idle;
        idle = draw_idle(send_calm);
        if (idle > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, count, upper[HalfW-1:0], upper[LabelW-1:HalfW],
                          lower[HalfW-1:0], lower[LabelW-1:HalfW]};
        do @(posedge clk); while (!s_axis_tready);
        if (known)
            push_label('0, known_status, 1'b1);
        else
            predict_labels(cmd, lower, upper, count);
    endtask

    task automatic wait_for_labels();
        while (expected_labels.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [HalfW-1:0] want,
                               input logic [HalfW-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        label_res_t want;
        int idle;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            idle = draw_idle(recv_calm);
            if (idle > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            if (expected_labels.size() == 0)
            begin
                $error("Unexpected result transaction: key %h, status %0d, last %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = expected_labels.pop_front();
                check_field("key_high", want.key_high, m_axis_tdata[HalfW-1:0]);
                check_field("key_low", want.key_low, m_axis_tdata[LabelW-1:HalfW]);
                check_field("status", 64'(want.status), 64'(m_axis_tuser));
                check_field("last", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    initial
    begin
        logic              cmd;
        logic [LabelW-1:0] lower;
        logic [LabelW-1:0] upper;
        logic [LabelW-1:0] gap;
        logic [CountW-1:0] count;
        int kind;
        int pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_split(directed_rows[i].cmd, directed_rows[i].left_label,
                       directed_rows[i].right_label, directed_rows[i].count,
                       directed_rows[i].known, directed_rows[i].known_status);

        // Let the pipeline empty fully before the random traffic begins.
        s_axis_tvalid <= 1'b0;
        wait_for_labels();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            cmd = ($urandom_range(0, 3) == 0) ? CMD_MIDPOINT : CMD_DISTRIBUTE;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                count = CountW'($urandom_range(1, 8));
            else if (pick < 8)
                count = CountW'($urandom_range(9, 64));
            else if (pick == 8)
                count = '0;
            else
                count = CountW'($urandom_range(65, 127));

            kind  = $urandom_range(0, 99);
            lower = random_label();
            if (kind < 85)
            begin
                if (kind < 70)
                    gap = random_label() >> $urandom_range(0, LabelW - 1);
                else
                    gap = LabelW'($urandom_range(0, 2 * int'(count) + 4));
                if (lower > ~gap)
                    lower = lower % (~gap + 1'b1);
                upper = lower + gap;
            end
            else
            begin
                upper = lower - LabelW'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 0)
                    upper = random_label();
                if (upper > lower)
                begin
                    gap   = upper;
                    upper = lower;
                    lower = gap;
                end
            end

            send_split(cmd, lower, upper, count, 1'b0, olgs_pkg::STATUS_OK);
            if (n % 150 == 149)
            begin
                s_axis_tvalid <= 1'b0;
                wait_for_labels();
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_for_labels();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
